@@ design/bisl_pkg.sv @@
`timescale 1ns / 1ps

package bisl_pkg;

    // Parser phase of the boot image.
    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_COUNT    = 3'd1,
        PH_ADDR     = 3'd2,
        PH_DATA     = 3'd3,
        PH_ENTRY    = 3'd4,
        PH_CHECK    = 3'd5,
        PH_FINISHED = 3'd6
    } phase_t;

    // Kind of one result transaction.
    typedef enum logic [2:0] {
        KIND_WRITE      = 3'd0,
        KIND_DONE_ENTRY = 3'd1,
        KIND_DONE_NONE  = 3'd2,
        KIND_BAD_SIG    = 3'd3,
        KIND_NO_EXEC    = 3'd4,
        KIND_BAD_TYPE   = 3'd5,
        KIND_BAD_SUM    = 3'd6
    } kind_t;

    // Header word fields and the write address step.
    localparam logic [7:0]  SIG_BYTE0   = 8'h43;
    localparam logic [7:0]  SIG_BYTE1   = 8'h59;
    localparam logic [7:0]  TYPE_NORMAL = 8'hB0;
    localparam logic [31:0] ADDR_STEP   = 32'd4;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [31:0] data_word;
        logic        last_result;
    } result_t;

    // Results produced by one accepted word, first one in "first".
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

@@ design/bisl_core.sv @@
`timescale 1ns / 1ps

module bisl_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [31:0]         image_word,
    input  logic                start_of_image,
    input  logic                end_of_image,
    output bisl_pkg::push_t     push
);

    bisl_pkg::phase_t phase_reg, phase_next;
    logic [31:0] words_left_reg, words_left_next;
    logic [31:0] write_address_reg, write_address_next;
    logic [31:0] running_sum_reg, running_sum_next;
    logic [31:0] entry_address_reg, entry_address_next;

    // State as seen by this word: a start mark clears everything first.
    bisl_pkg::phase_t cur_phase;
    logic [31:0] cur_words_left;
    logic [31:0] cur_write_address;
    logic [31:0] cur_running_sum;
    logic [31:0] cur_entry_address;
    logic [31:0] words_dec;

    bisl_pkg::result_t main_res;
    bisl_pkg::result_t end_res;
    logic              main_valid;
    logic              end_valid;
    bisl_pkg::phase_t  step_phase;

    assign cur_phase         = start_of_image ? bisl_pkg::PH_HEADER : phase_reg;
    assign cur_words_left    = start_of_image ? 32'd0 : words_left_reg;
    assign cur_write_address = start_of_image ? 32'd0 : write_address_reg;
    assign cur_running_sum   = start_of_image ? 32'd0 : running_sum_reg;
    assign cur_entry_address = start_of_image ? 32'd0 : entry_address_reg;
    assign words_dec         = cur_words_left - 32'd1;

    // Per-phase handling of the word.
    always_comb
    begin
        step_phase         = cur_phase;
        words_left_next    = cur_words_left;
        write_address_next = cur_write_address;
        running_sum_next   = cur_running_sum;
        entry_address_next = cur_entry_address;
        main_valid         = 1'b0;
        main_res           = '{kind: bisl_pkg::KIND_WRITE, address: 32'd0,
                               data_word: 32'd0, last_result: 1'b0};
        unique case (cur_phase)
            bisl_pkg::PH_HEADER:
            begin
                priority if (image_word[7:0] != bisl_pkg::SIG_BYTE0 ||
                             image_word[15:8] != bisl_pkg::SIG_BYTE1)
                begin
                    main_valid    = 1'b1;
                    main_res.kind = bisl_pkg::KIND_BAD_SIG;
                    step_phase    = bisl_pkg::PH_FINISHED;
                end
                else if (image_word[16])
                begin
                    main_valid    = 1'b1;
                    main_res.kind = bisl_pkg::KIND_NO_EXEC;
                    step_phase    = bisl_pkg::PH_FINISHED;
                end
                else if (image_word[31:24] != bisl_pkg::TYPE_NORMAL)
                begin
                    main_valid    = 1'b1;
                    main_res.kind = bisl_pkg::KIND_BAD_TYPE;
                    step_phase    = bisl_pkg::PH_FINISHED;
                end
                else
                begin
                    step_phase = bisl_pkg::PH_COUNT;
                end
            end
            bisl_pkg::PH_COUNT:
            begin
                words_left_next = image_word;
                step_phase = (image_word == 32'd0) ? bisl_pkg::PH_ENTRY
                                                   : bisl_pkg::PH_ADDR;
            end
            bisl_pkg::PH_ADDR:
            begin
                write_address_next = image_word;
                step_phase         = bisl_pkg::PH_DATA;
            end
            bisl_pkg::PH_DATA:
            begin
                main_valid         = 1'b1;
                main_res.kind      = bisl_pkg::KIND_WRITE;
                main_res.address   = cur_write_address;
                main_res.data_word = image_word;
                write_address_next = cur_write_address + bisl_pkg::ADDR_STEP;
                running_sum_next   = cur_running_sum + image_word;
                words_left_next    = words_dec;
                if (words_dec == 32'd0)
                begin
                    step_phase = bisl_pkg::PH_COUNT;
                end
            end
            bisl_pkg::PH_ENTRY:
            begin
                entry_address_next = image_word;
                step_phase         = bisl_pkg::PH_CHECK;
            end
            bisl_pkg::PH_CHECK:
            begin
                main_valid = 1'b1;
                if (image_word == cur_running_sum)
                begin
                    main_res.kind    = bisl_pkg::KIND_DONE_ENTRY;
                    main_res.address = cur_entry_address;
                end
                else
                begin
                    main_res.kind = bisl_pkg::KIND_BAD_SUM;
                end
                step_phase = bisl_pkg::PH_FINISHED;
            end
            default:
            begin
                step_phase = cur_phase;
            end
        endcase
    end

    // An end mark before the image is finished reports done without entry.
    always_comb
    begin
        end_valid   = end_of_image && (step_phase != bisl_pkg::PH_FINISHED);
        end_res     = '{kind: bisl_pkg::KIND_DONE_NONE, address: 32'd0,
                        data_word: 32'd0, last_result: 1'b1};
        phase_next  = end_valid ? bisl_pkg::PH_FINISHED : step_phase;
    end

    // Order the results and mark the last one.
    always_comb
    begin
        push.count  = {1'b0, main_valid} + {1'b0, end_valid};
        push.second = end_res;
        if (main_valid)
        begin
            push.first             = main_res;
            push.first.last_result = !end_valid;
        end
        else
        begin
            push.first = end_res;
        end
    end

    // State registers, updated per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= bisl_pkg::PH_HEADER;
            words_left_reg    <= 32'd0;
            write_address_reg <= 32'd0;
            running_sum_reg   <= 32'd0;
            entry_address_reg <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            words_left_reg    <= words_left_next;
            write_address_reg <= write_address_next;
            running_sum_reg   <= running_sum_next;
            entry_address_reg <= entry_address_next;
        end
    end

    // Two results only ever end with the early-end report.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && push.count == 2'd2) |-> push.second.kind == bisl_pkg::KIND_DONE_NONE)
        else $error("second result is not an early-end report");

    // A finished image ignores words without a start mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !start_of_image && phase_reg == bisl_pkg::PH_FINISHED)
            |-> push.count == 2'd0)
        else $error("finished image produced a result");

    // The data phase is only entered with words still to write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == bisl_pkg::PH_DATA) |-> words_left_reg != 32'd0)
        else $error("data phase with zero words left");

endmodule

@@ design/bisl_out_fifo.sv @@
`timescale 1ns / 1ps

module bisl_out_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  bisl_pkg::push_t     push,
    output logic                has_room,
    output logic                out_valid,
    input  logic                out_ready,
    output bisl_pkg::result_t   out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bisl_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_ptr_plus1;
    logic [PTR_W-1:0]  wr_ptr_plus2;
    logic [1:0]        push_n;
    logic              pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    assign push_n       = push_en ? push.count : 2'd0;
    assign pop          = out_valid && out_ready;
    assign has_room     = count_reg <= ROOM_MAX;
    assign out_valid    = count_reg != '0;
    assign out_data     = mem_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign wr_ptr_plus2 = ptr_inc(wr_ptr_plus1);

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case (push_n)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = wr_ptr_plus2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage, up to two entries written per cycle.
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> has_room)
        else $error("push into queue without room");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("fill count moved without traffic");

endmodule

@@ design/boot_image_section_loader_unit.sv @@
`timescale 1ns / 1ps
// A result enters the result queue registers when its word is accepted.
// Throughput: one image word per cycle; a word can add up to two results to the
// result queue, which takes input while it has room for two entries.
// Reset (rst_n, asynchronous, active low) puts the parser in the header phase with
// counters, address, sum and entry cleared, and empties the result queue.

module boot_image_section_loader_unit
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Image word transaction.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] image_word
    input  logic [0:0]  s_axis_tuser,   // [0] start_of_image
    input  logic        s_axis_tlast,   // end_of_image
    // Result transaction.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] address, [63:32] data_word
    output logic [2:0]  m_axis_tuser,   // [2:0] result_kind
    output logic        m_axis_tlast    // last_result
);

    bisl_pkg::push_t   push;
    bisl_pkg::result_t out_res;
    logic              accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Parser state and per-word result generation.
    bisl_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .image_word     (s_axis_tdata),
        .start_of_image (s_axis_tuser[0]),
        .end_of_image   (s_axis_tlast),
        .push           (push)
    );

    // Result queue between the parser and the output port.
    bisl_out_fifo #(.DEPTH(FIFO_DEPTH)) u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (push),
        .has_room  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = {out_res.data_word, out_res.address};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last_result;

endmodule
